[rtl/abrf_pkg.sv]
// abrf_pkg: shared types, mode codes and the mode-to-bank mapping
// for the banked register file; no dependencies
package abrf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ModeW  = 5;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned Depth  = 36;
  localparam int unsigned EntryW = $clog2(Depth);

  // processor mode codes
  localparam logic [ModeW-1:0] MODE_USR = 5'd16;
  localparam logic [ModeW-1:0] MODE_FIQ = 5'd17;
  localparam logic [ModeW-1:0] MODE_IRQ = 5'd18;
  localparam logic [ModeW-1:0] MODE_SVC = 5'd19;
  localparam logic [ModeW-1:0] MODE_ABT = 5'd23;
  localparam logic [ModeW-1:0] MODE_UND = 5'd27;
  localparam logic [ModeW-1:0] MODE_SYS = 5'd31;

  // logical register numbers with a special meaning
  localparam logic [IdxW-1:0] IDX_R8   = 5'd8;
  localparam logic [IdxW-1:0] IDX_SP   = 5'd13;
  localparam logic [IdxW-1:0] IDX_LR   = 5'd14;
  localparam logic [IdxW-1:0] IDX_PC   = 5'd15;
  localparam logic [IdxW-1:0] IDX_CPSR = 5'd16;
  localparam logic [IdxW-1:0] IDX_SPSR = 5'd17;

  // storage entries of the small banks (r13, r14, spsr follow the base)
  localparam logic [EntryW-1:0] BASE_SVC = 6'd16;
  localparam logic [EntryW-1:0] BASE_ABT = 6'd19;
  localparam logic [EntryW-1:0] BASE_UND = 6'd22;
  localparam logic [EntryW-1:0] BASE_IRQ = 6'd25;
  // fiq r8 sits at entry 28, fiq spsr at entry 35
  localparam logic [EntryW-1:0] FIQ_R8_ENTRY   = 6'd28;
  localparam logic [EntryW-1:0] FIQ_SPSR_ENTRY = 6'd35;

  typedef enum logic [2:0] {
    KIND_RD_BANKED = 3'd0,
    KIND_WR_BANKED = 3'd1,
    KIND_RD_USER   = 3'd2,
    KIND_WR_USER   = 3'd3,
    KIND_RD_CPSR   = 3'd4,
    KIND_WR_CPSR   = 3'd5,
    KIND_RD_SPSR   = 3'd6,
    KIND_WR_SPSR   = 3'd7
  } kind_t;

  typedef struct packed {
    logic              ok;
    logic              is_write;
    logic              is_cpsr;
    logic [EntryW-1:0] entry;
  } access_t;

  // map a logical register in a mode onto the cpsr or a storage entry
  function automatic access_t resolve(logic [ModeW-1:0] mode, logic [IdxW-1:0] idx);
    access_t           a;
    logic [EntryW-1:0] base;
    logic              small_bank;
    a          = '0;
    base       = '0;
    small_bank = 1'b0;
    unique case (mode)
      MODE_SVC: begin base = BASE_SVC; small_bank = 1'b1; end
      MODE_ABT: begin base = BASE_ABT; small_bank = 1'b1; end
      MODE_UND: begin base = BASE_UND; small_bank = 1'b1; end
      MODE_IRQ: begin base = BASE_IRQ; small_bank = 1'b1; end
      default:  begin base = '0; small_bank = 1'b0; end
    endcase
    if (idx <= IDX_SPSR) begin
      if (mode == MODE_FIQ) begin
        a.ok = 1'b1;
        if (idx == IDX_CPSR) begin
          a.is_cpsr = 1'b1;
        end else if (idx < IDX_R8 || idx == IDX_PC) begin
          a.entry = {1'b0, idx};
        end else if (idx == IDX_SPSR) begin
          a.entry = FIQ_SPSR_ENTRY;
        end else begin
          a.entry = FIQ_R8_ENTRY + {1'b0, idx - IDX_R8};
        end
      end else if (mode == MODE_USR || mode == MODE_SYS) begin
        a.ok      = (idx != IDX_SPSR);
        a.is_cpsr = (idx == IDX_CPSR);
        a.entry   = {1'b0, idx};
      end else if (small_bank) begin
        a.ok = 1'b1;
        if (idx == IDX_CPSR) begin
          a.is_cpsr = 1'b1;
        end else if (idx == IDX_SP) begin
          a.entry = base;
        end else if (idx == IDX_LR) begin
          a.entry = base + 6'd1;
        end else if (idx == IDX_SPSR) begin
          a.entry = base + 6'd2;
        end else begin
          a.entry = {1'b0, idx};
        end
      end
    end
    return a;
  endfunction

endpackage

[rtl/abrf_decode.sv]
// abrf_decode: turns one access request and the current mode into an
// access descriptor; depends on abrf_pkg
module abrf_decode (
  input  logic [2:0]                       kind,
  input  logic [abrf_pkg::IdxW-1:0]        reg_index,
  input  logic [abrf_pkg::ModeW-1:0]       mode,
  output abrf_pkg::access_t                acc
);

  abrf_pkg::access_t res;

  always_comb begin
    acc = '0;
    res = '0;
    unique case (abrf_pkg::kind_t'(kind))
      abrf_pkg::KIND_RD_BANKED, abrf_pkg::KIND_WR_BANKED: begin
        acc = abrf_pkg::resolve(mode, reg_index);
      end
      abrf_pkg::KIND_RD_USER, abrf_pkg::KIND_WR_USER: begin
        acc.ok      = (reg_index <= abrf_pkg::IDX_CPSR);
        acc.is_cpsr = (reg_index == abrf_pkg::IDX_CPSR);
        acc.entry   = {1'b0, reg_index};
      end
      abrf_pkg::KIND_RD_CPSR, abrf_pkg::KIND_WR_CPSR: begin
        acc.ok      = 1'b1;
        acc.is_cpsr = 1'b1;
      end
      default: begin
        res = abrf_pkg::resolve(mode, abrf_pkg::IDX_SPSR);
        acc = res;
      end
    endcase
    unique case (abrf_pkg::kind_t'(kind))
      abrf_pkg::KIND_WR_BANKED, abrf_pkg::KIND_WR_USER,
      abrf_pkg::KIND_WR_CPSR, abrf_pkg::KIND_WR_SPSR: acc.is_write = 1'b1;
      default:                                        acc.is_write = 1'b0;
    endcase
  end

endmodule

[rtl/arm_banked_register_file.sv]
// arm_banked_register_file: top level of the banked register file with the
// cpsr, the 36-entry register store and the result register
// depends on abrf_pkg and abrf_decode
//
// usage
//   one access is a beat of kind, reg_index and write_value, taken at a
//   rising edge with start high and busy low; busy is always low, so a
//   new beat can be taken in every cycle
//   each beat gives exactly one result beat in the next cycle: read_data,
//   access_error, current_mode, has_saved_status and privileged, shown
//   for one cycle with done high
//   throughput 1 beat per cycle; the store has one write and one registered
//   read port; every beat uses the read port, a store write both of them
//   writes to the store and the cpsr land at the accepting edge, so the
//   next beat already sees the new mode and data
//   the receiver has no way to stall; results must be taken as shown
//   reset clears the cpsr (reserved mode, so banked and spsr accesses
//   report an error until a mode is written) and the done strobe; the
//   store itself is not cleared and is undefined until written
module arm_banked_register_file (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [abrf_pkg::IdxW-1:0]     reg_index,
  input  logic [abrf_pkg::DataW-1:0]    write_value,
  output logic                          done,
  output logic [abrf_pkg::DataW-1:0]    read_data,
  output logic                          access_error,
  output logic [abrf_pkg::ModeW-1:0]    current_mode,
  output logic                          has_saved_status,
  output logic                          privileged
);

  // architectural state
  logic [abrf_pkg::DataW-1:0] status_word;
  logic [abrf_pkg::DataW-1:0] bank_mem [abrf_pkg::Depth];

  // result register
  logic [abrf_pkg::DataW-1:0] mem_rdata;
  logic [abrf_pkg::DataW-1:0] cpsr_rdata;
  logic                       rd_ok;
  logic                       rd_cpsr;
  logic                       err;
  logic [abrf_pkg::ModeW-1:0] mode_after;

  abrf_pkg::access_t          acc;
  logic                       accept;

  // no multi-cycle work, so the block never holds off a request
  assign busy   = 1'b0;
  assign accept = start && !busy;

  abrf_decode u_decode (
    .kind      (kind),
    .reg_index (reg_index),
    .mode      (status_word[abrf_pkg::ModeW-1:0]),
    .acc       (acc)
  );

  // cpsr and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      status_word <= '0;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (accept && acc.ok && acc.is_write && acc.is_cpsr) begin
        status_word <= write_value;
      end
    end
  end

  // register store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && acc.ok && acc.is_write && !acc.is_cpsr) begin
      bank_mem[acc.entry] <= write_value;
    end
    if (accept) begin
      mem_rdata <= bank_mem[acc.entry];
    end
  end

  // result payload, captured alongside the store read
  always_ff @(posedge clk) begin
    if (accept) begin
      cpsr_rdata <= status_word;
      rd_ok      <= acc.ok && !acc.is_write;
      rd_cpsr    <= acc.is_cpsr;
      err        <= !acc.ok;
      // mode as it stands once this beat's write has landed
      if (acc.ok && acc.is_write && acc.is_cpsr) begin
        mode_after <= write_value[abrf_pkg::ModeW-1:0];
      end else begin
        mode_after <= status_word[abrf_pkg::ModeW-1:0];
      end
    end
  end

  // writes and refused accesses read as zero
  assign read_data        = !rd_ok ? '0 : (rd_cpsr ? cpsr_rdata : mem_rdata);
  assign access_error     = err;
  assign current_mode     = mode_after;
  assign has_saved_status = (mode_after != abrf_pkg::MODE_USR) &&
                            (mode_after != abrf_pkg::MODE_SYS);
  assign privileged       = (mode_after != abrf_pkg::MODE_USR);

endmodule
